// ===== rtl/core/att_pkg.sv =====
// ----------------------------------------------------------------------------
// att_pkg
// Shared types, constants and the arctangent table of the tilt-to-pixel block.
// ----------------------------------------------------------------------------
package att_pkg;

  localparam int DEF_DISPLAY_WIDTH       = 128;
  localparam int DEF_DISPLAY_HEIGHT      = 32;
  localparam int DEF_ANGLE_FRACTION_BITS = 8;

  localparam int ACC_FRAC     = 24;
  localparam int CORDIC_STEPS = 24;
  localparam int OPERAND_SH   = 20;
  localparam int CX_W         = 40;
  localparam int Z_W          = 34;
  localparam int STEP_W       = 5;
  localparam int CFG_W        = 8;

  localparam logic [CFG_W-1:0] FS_RESET = 8'd45;

  localparam logic signed [Z_W-1:0] Z_DEG90 = 34'sd1509949440;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORD,
    ST_DIFF,
    ST_SCALE,
    ST_DIVGO,
    ST_DIV,
    ST_DONE
  } att_state_t;

  function automatic logic signed [Z_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = 34'sd754974720;
      5'd1:    v = 34'sd445687602;
      5'd2:    v = 34'sd235489088;
      5'd3:    v = 34'sd119537938;
      5'd4:    v = 34'sd60000934;
      5'd5:    v = 34'sd30029717;
      5'd6:    v = 34'sd15018523;
      5'd7:    v = 34'sd7509720;
      5'd8:    v = 34'sd3754917;
      5'd9:    v = 34'sd1877466;
      5'd10:   v = 34'sd938734;
      5'd11:   v = 34'sd469367;
      5'd12:   v = 34'sd234684;
      5'd13:   v = 34'sd117342;
      5'd14:   v = 34'sd58671;
      5'd15:   v = 34'sd29335;
      5'd16:   v = 34'sd14668;
      5'd17:   v = 34'sd7334;
      5'd18:   v = 34'sd3667;
      5'd19:   v = 34'sd1833;
      5'd20:   v = 34'sd917;
      5'd21:   v = 34'sd458;
      5'd22:   v = 34'sd229;
      5'd23:   v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/att_if.sv =====
// ----------------------------------------------------------------------------
// att_in_if / att_out_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface att_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, operation, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, operation, accel_x, accel_y, accel_z, output ready);
endinterface

interface att_out_if #(parameter int ANG_W = 18, parameter int COL_W = 7,
                       parameter int ROW_W = 5);
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] roll_out;
  logic signed [ANG_W-1:0] pitch_out;
  logic signed [ANG_W-1:0] yaw_out;
  logic        [COL_W-1:0] pixel_col;
  logic        [ROW_W-1:0] pixel_row;
  modport source (output valid, roll_out, pitch_out, yaw_out, pixel_col, pixel_row,
                  input ready);
  modport sink   (input valid, roll_out, pitch_out, yaw_out, pixel_col, pixel_row,
                  output ready);
endinterface

// ===== rtl/core/accel_tilt_to_pixel.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_to_pixel
// Roll, pitch and yaw from a three-axis sample, offset-corrected and mapped
// to a display column and row.
// Flow: 24 CORDIC steps, the states DIFF, SCALE and DIVGO, bit-serial division,
//   then DONE loads the result registers.
// A sample is taken only in IDLE, so a held result stalls the input.
// Calibrate loads the zero offsets from the last angles and gives no result.
// Reset: synchronous active-low; angles and offsets clear, full scale is 45.
// ----------------------------------------------------------------------------
module accel_tilt_to_pixel
  import att_pkg::*;
#(
  parameter int DISPLAY_WIDTH       = DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT      = DEF_DISPLAY_HEIGHT,
  parameter int ANGLE_FRACTION_BITS = DEF_ANGLE_FRACTION_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  att_in_if.sink           in_ch,
  att_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int F     = ANGLE_FRACTION_BITS;
  localparam int ANG_W = F + 9;
  localparam int OUT_W = F + 10;
  localparam int COL_W = $clog2(DISPLAY_WIDTH - 1);
  localparam int ROW_W = $clog2(DISPLAY_HEIGHT - 1);

  att_state_t state_r, state_nxt;

  logic [CFG_W-1:0]        fs_r;
  logic signed [ANG_W-1:0] last_roll_r, last_pitch_r, last_yaw_r;
  logic signed [ANG_W-1:0] roll_zero_r, pitch_zero_r, yaw_zero_r;
  logic signed [OUT_W-1:0] d_roll_r, d_pitch_r, d_yaw_r;
  logic [F+9:0]            sa_roll_r, sa_pitch_r;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] o_roll_r, o_pitch_r, o_yaw_r;
  logic [COL_W-1:0]        o_col_r;
  logic [ROW_W-1:0]        o_row_r;

  logic                    take, cal, cord_go, div_go, load_out;
  logic                    dn_r, dn_p, dn_y, dn_c, dn_w;
  logic signed [ANG_W-1:0] a_roll, a_pitch, a_yaw;
  logic [COL_W-1:0]        q_col;
  logic [ROW_W-1:0]        q_row;
  logic [F+7:0]            s_u;
  logic signed [OUT_W-1:0] s_s, c_roll, c_pitch;

  assign take    = in_ch.valid && in_ch.ready;
  assign cal     = take && in_ch.operation;
  assign cord_go = take && !in_ch.operation;

  att_cordic #(.F(F)) u_roll (
    .clk(clk), .rst_n(rst_n), .start(cord_go), .y_in(in_ch.accel_y),
    .x_in(in_ch.accel_z), .done(dn_r), .angle(a_roll));
  att_cordic #(.F(F)) u_pitch (
    .clk(clk), .rst_n(rst_n), .start(cord_go), .y_in(in_ch.accel_x),
    .x_in(in_ch.accel_z), .done(dn_p), .angle(a_pitch));
  att_cordic #(.F(F)) u_yaw (
    .clk(clk), .rst_n(rst_n), .start(cord_go), .y_in(in_ch.accel_y),
    .x_in(in_ch.accel_x), .done(dn_y), .angle(a_yaw));

  assign s_u = (F+8)'((fs_r == '0) ? CFG_W'(1) : fs_r) << F;
  assign s_s = OUT_W'(s_u);

  always_comb begin
    c_roll = d_roll_r;
    if (d_roll_r > s_s) c_roll = s_s;
    if (d_roll_r < -s_s) c_roll = -s_s;
    c_pitch = d_pitch_r;
    if (d_pitch_r > s_s) c_pitch = s_s;
    if (d_pitch_r < -s_s) c_pitch = -s_s;
  end

  assign div_go = (state_r == ST_DIVGO);

  att_pixdiv #(.SPAN(DISPLAY_WIDTH), .F(F)) u_col (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(sa_roll_r),
    .den({s_u, 1'b0}), .done(dn_c), .quo(q_col));
  att_pixdiv #(.SPAN(DISPLAY_HEIGHT), .F(F)) u_row (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(sa_pitch_r),
    .den({s_u, 1'b0}), .done(dn_w), .quo(q_row));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (cord_go) state_nxt = ST_CORD;
      ST_CORD:  if (dn_r && dn_p && dn_y) state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DIVGO;
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV:   if (dn_c && dn_w) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_DONE: load_out    = !out_valid_r || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
        load_out    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fs_r         <= FS_RESET;
      last_roll_r  <= '0;
      last_pitch_r <= '0;
      last_yaw_r   <= '0;
      roll_zero_r  <= '0;
      pitch_zero_r <= '0;
      yaw_zero_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) fs_r <= cfg_wdata;
      if (cal) begin
        roll_zero_r  <= last_roll_r;
        pitch_zero_r <= last_pitch_r;
        yaw_zero_r   <= last_yaw_r;
      end
      if (state_r == ST_DIFF) begin
        last_roll_r  <= a_roll;
        last_pitch_r <= a_pitch;
        last_yaw_r   <= a_yaw;
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIFF) begin
      d_roll_r  <= OUT_W'(roll_zero_r) - OUT_W'(a_roll);
      d_pitch_r <= OUT_W'(pitch_zero_r) - OUT_W'(a_pitch);
      d_yaw_r   <= OUT_W'(yaw_zero_r) - OUT_W'(a_yaw);
    end
    if (state_r == ST_SCALE) begin
      sa_roll_r  <= (F+10)'(s_s + c_roll);
      sa_pitch_r <= (F+10)'(s_s + c_pitch);
    end
    if (load_out) begin
      o_roll_r  <= d_roll_r;
      o_pitch_r <= d_pitch_r;
      o_yaw_r   <= d_yaw_r;
      o_col_r   <= q_col;
      o_row_r   <= q_row;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.roll_out  = o_roll_r;
  assign out_ch.pitch_out = o_pitch_r;
  assign out_ch.yaw_out   = o_yaw_r;
  assign out_ch.pixel_col = o_col_r;
  assign out_ch.pixel_row = o_row_r;

  a_cal_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    cal |=> !$rose(out_valid_r))
    else $error("calibrate produced a result");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_col_r <= COL_W'(DISPLAY_WIDTH - 2)))
    else $error("pixel column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_row_r <= ROW_W'(DISPLAY_HEIGHT - 2)))
    else $error("pixel row out of range");

  a_lanes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dn_r && dn_p && dn_y))
    else $error("CORDIC lane busy during division");

endmodule

// ===== rtl/core/att_cordic.sv =====
// ----------------------------------------------------------------------------
// att_cordic
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module att_cordic
  import att_pkg::*;
#(
  parameter int F = DEF_ANGLE_FRACTION_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [15:0]  y_in,
  input  logic signed [15:0]  x_in,
  output logic                done,
  output logic signed [F+8:0] angle
);

  localparam int ANG_W = F + 9;

  logic signed [CX_W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [Z_W-1:0]   z_r, z_nxt;
  logic [STEP_W-1:0]       cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    spec_r, spec_nxt;
  logic signed [ANG_W-1:0] sval_r, sval_nxt;
  logic signed [CX_W-1:0]  ix, iy, sx, sy;
  logic signed [Z_W-1:0]   zr;

  always_comb begin
    ix = CX_W'(x_in) <<< OPERAND_SH;
    iy = CX_W'(y_in) <<< OPERAND_SH;
    sx = cx_r >>> cnt_r;
    sy = cy_r >>> cnt_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    spec_nxt = spec_r;
    sval_nxt = sval_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      spec_nxt = (y_in == 16'sd0) || (x_in == 16'sd0);
      if (y_in == 16'sd0) begin
        sval_nxt = (x_in < 16'sd0) ? (ANG_W'(180) <<< F) : '0;
      end else begin
        sval_nxt = (y_in > 16'sd0) ? (ANG_W'(90) <<< F) : -(ANG_W'(90) <<< F);
      end
      if (ix < 0) begin
        if (iy >= 0) begin
          cx_nxt = iy;
          cy_nxt = -ix;
          z_nxt  = Z_DEG90;
        end else begin
          cx_nxt = -iy;
          cy_nxt = ix;
          z_nxt  = -Z_DEG90;
        end
      end else begin
        cx_nxt = ix;
        cy_nxt = iy;
        z_nxt  = '0;
      end
    end else if (busy_r) begin
      if (cy_r >= 0) begin
        cx_nxt = cx_r + sy;
        cy_nxt = cy_r - sx;
        z_nxt  = z_r + atan_deg(cnt_r);
      end else begin
        cx_nxt = cx_r - sy;
        cy_nxt = cy_r + sx;
        z_nxt  = z_r - atan_deg(cnt_r);
      end
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    z_r    <= z_nxt;
    spec_r <= spec_nxt;
    sval_r <= sval_nxt;
  end

  assign zr    = z_r + (Z_W'(1) <<< (ACC_FRAC - F - 1));
  assign done  = !busy_r;
  assign angle = spec_r ? sval_r : ANG_W'(zr >>> (ACC_FRAC - F));

endmodule

// ===== rtl/core/att_pixdiv.sv =====
// ----------------------------------------------------------------------------
// att_pixdiv
// Display coordinate: (SPAN-2)*num / den, restoring division one bit a cycle.
// ----------------------------------------------------------------------------
module att_pixdiv
  import att_pkg::*;
#(
  parameter int SPAN = DEF_DISPLAY_WIDTH,
  parameter int F    = DEF_ANGLE_FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [F+9:0]                  num,
  input  logic [F+8:0]                  den,
  output logic                          done,
  output logic [$clog2(SPAN-1)-1:0]     quo
);

  localparam int QW = $clog2(SPAN - 1);
  localparam int KW = $clog2(QW + 1);
  localparam int NW = F + 18;

  logic [NW-1:0] rem_r, rem_nxt;
  logic [F+8:0]  dv_r, dv_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [KW-1:0] kidx;
  logic [NW-1:0] shd;

  always_comb begin
    kidx    = k_r - KW'(1);
    shd     = NW'(dv_r) << kidx;
    rem_nxt = rem_r;
    dv_nxt  = dv_r;
    k_nxt   = k_r;
    q_nxt   = q_r;
    if (start) begin
      rem_nxt = NW'(num) * NW'(SPAN - 2);
      dv_nxt  = den;
      k_nxt   = KW'(QW);
      q_nxt   = '0;
    end else if (k_r != '0) begin
      if (rem_r >= shd) begin
        rem_nxt = rem_r - shd;
        q_nxt   = q_r | (QW'(1) << kidx);
      end
      k_nxt = kidx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      k_r <= k_nxt;
    end
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    q_r   <= q_nxt;
  end

  assign done = (k_r == '0);
  assign quo  = q_r;

endmodule
